// ===== design/hvn_pkg.sv =====
// Shared constants for the heightmap vertex normal unit.
// No dependencies; imported by the lane, merge and top-level modules.
package hvn_pkg;

    localparam int HEIGHT_BITS_DEF      = 8;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int GUARD_BITS           = 4;
    localparam int LEN_HALF_SHIFT       = 12;
    localparam int Z_CROSS              = 4;
    localparam int NUM_LANES            = 6;
    localparam int NUM_PAIRS            = NUM_LANES / 2;
    localparam int NUM_HEIGHTS          = 7;
    localparam int NUM_FLAGS            = 4;
    localparam int NORM_W               = 16;

    localparam int H_CENTER     = 0;
    localparam int H_LEFT       = 1;
    localparam int H_DOWN       = 2;
    localparam int H_UP_LEFT    = 3;
    localparam int H_UP         = 4;
    localparam int H_DOWN_RIGHT = 5;
    localparam int H_RIGHT      = 6;

    localparam int F_LEFT  = 0;
    localparam int F_RIGHT = 1;
    localparam int F_DOWN  = 2;
    localparam int F_UP    = 3;

    localparam int C_X = 0;
    localparam int C_Y = 1;
    localparam int C_Z = 2;

endpackage

// ===== design/hvn_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side tag.
// Generic; no package dependencies.
module hvn_isqrt #(
    parameter int RAD_W = 44,
    parameter int TAG_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [RAD_W-1:0]     rad,
    input  logic [TAG_W-1:0]     tag_in,
    output logic                 vld_out,
    output logic [RAD_W/2-1:0]   root,
    output logic [TAG_W-1:0]     tag_out
);

    localparam int OUT_W = RAD_W / 2;

    logic [RAD_W-1:0] v_reg    [OUT_W];
    logic [RAD_W-1:0] v_next   [OUT_W];
    logic [RAD_W-1:0] res_reg  [OUT_W];
    logic [RAD_W-1:0] res_next [OUT_W];
    logic [TAG_W-1:0] tag_reg  [OUT_W];
    logic [TAG_W-1:0] tag_next [OUT_W];
    logic [OUT_W-1:0] vld_reg;
    logic [OUT_W-1:0] vld_next;

    always_comb
    begin
        logic [RAD_W-1:0] v_in   [OUT_W];
        logic [RAD_W-1:0] r_in   [OUT_W];
        logic [RAD_W:0]   bitv;
        logic [RAD_W:0]   trial;
        v_in[0]   = rad;
        r_in[0]   = '0;
        tag_next[0] = tag_in;
        for (int j = 1; j < OUT_W; j++)
        begin
            v_in[j]     = v_reg[j-1];
            r_in[j]     = res_reg[j-1];
            tag_next[j] = tag_reg[j-1];
        end
        for (int j = 0; j < OUT_W; j++)
        begin
            bitv  = (RAD_W+1)'(1) << (RAD_W - 2 - 2*j);
            trial = {1'b0, r_in[j]} + bitv;
            if ({1'b0, v_in[j]} >= trial)
            begin
                v_next[j]   = RAD_W'({1'b0, v_in[j]} - trial);
                res_next[j] = RAD_W'(({1'b0, r_in[j]} >> 1) + bitv);
            end
            else
            begin
                v_next[j]   = v_in[j];
                res_next[j] = r_in[j] >> 1;
            end
        end
        vld_next = {vld_reg[OUT_W-2:0], vld_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
            tag_reg <= tag_next;
        end
    end

    assign vld_out = vld_reg[OUT_W-1];
    assign root    = res_reg[OUT_W-1][OUT_W-1:0];
    assign tag_out = tag_reg[OUT_W-1];

endmodule

// ===== design/hvn_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with a side tag.
// Generic; no package dependencies. Requires num < den * 2^Q_W.
module hvn_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 24,
    parameter int Q_W   = 19,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             vld_out,
    output logic [Q_W-1:0]   quo,
    output logic [TAG_W-1:0] tag_out
);

    logic [DEN_W-1:0] rem_reg  [Q_W];
    logic [DEN_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   low_reg  [Q_W];
    logic [Q_W-1:0]   low_next [Q_W];
    logic [Q_W-1:0]   q_reg    [Q_W];
    logic [Q_W-1:0]   q_next   [Q_W];
    logic [DEN_W-1:0] den_reg  [Q_W];
    logic [DEN_W-1:0] den_next [Q_W];
    logic [TAG_W-1:0] tag_reg  [Q_W];
    logic [TAG_W-1:0] tag_next [Q_W];
    logic [Q_W-1:0]   vld_reg;
    logic [Q_W-1:0]   vld_next;

    always_comb
    begin
        logic [DEN_W-1:0] rem_in [Q_W];
        logic [Q_W-1:0]   low_in [Q_W];
        logic [Q_W-1:0]   q_in   [Q_W];
        logic [DEN_W:0]   t;
        logic             ge;
        rem_in[0]   = DEN_W'(num >> Q_W);
        low_in[0]   = num[Q_W-1:0];
        q_in[0]     = '0;
        den_next[0] = den;
        tag_next[0] = tag_in;
        for (int j = 1; j < Q_W; j++)
        begin
            rem_in[j]   = rem_reg[j-1];
            low_in[j]   = low_reg[j-1];
            q_in[j]     = q_reg[j-1];
            den_next[j] = den_reg[j-1];
            tag_next[j] = tag_reg[j-1];
        end
        for (int j = 0; j < Q_W; j++)
        begin
            t  = {rem_in[j], low_in[j][Q_W-1]};
            ge = (t >= {1'b0, den_next[j]});
            rem_next[j] = ge ? DEN_W'(t - {1'b0, den_next[j]}) : DEN_W'(t);
            low_next[j] = low_in[j] << 1;
            q_next[j]   = {q_in[j][Q_W-2:0], ge};
        end
        vld_next = {vld_reg[Q_W-2:0], vld_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            q_reg   <= q_next;
            den_reg <= den_next;
            tag_reg <= tag_next;
        end
    end

    assign vld_out = vld_reg[Q_W-1];
    assign quo     = q_reg[Q_W-1];
    assign tag_out = tag_reg[Q_W-1];

endmodule

// ===== design/hvn_lane.sv =====
// One triangle lane: cross product (x, y, 4) to a rounded unit vector.
// Depends on hvn_pkg, hvn_isqrt and hvn_div.
module hvn_lane #(
    parameter int HB = hvn_pkg::HEIGHT_BITS_DEF,
    parameter int UB = hvn_pkg::NORMAL_FRAC_BITS_DEF + hvn_pkg::GUARD_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  logic                live_in,
    input  logic signed [HB:0]  x_in,
    input  logic signed [HB:0]  y_in,
    output logic                vld_out,
    output logic                live_out,
    output logic signed [UB+1:0] nx,
    output logic signed [UB+1:0] ny,
    output logic signed [UB+1:0] nz
);

    import hvn_pkg::*;

    localparam int C_W   = HB + 1;
    localparam int S_W   = 2 * C_W;
    localparam int RAD_W = S_W + 2 * LEN_HALF_SHIFT;
    localparam int L_W   = RAD_W / 2;
    localparam int DEN_W = L_W + 1;
    localparam int Q_W   = UB + 1;
    localparam int SH    = UB + LEN_HALF_SHIFT + 1;
    localparam int NUM_W = HB + SH + 1;
    localparam int TAG_W = 2 * C_W + 1;

    logic                  vld0_reg, vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic                  live0_reg, live1_reg, live2_reg, live3_reg;
    logic signed [C_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [S_W-1:0]        sqx_reg, sqy_reg, s_reg;
    logic signed [S_W-1:0] sqx_next, sqy_next;
    logic [NUM_W-1:0]      numx_reg, numy_reg, numz_reg;
    logic [DEN_W-1:0]      den_reg;
    logic                  sx_reg, sy_reg;
    logic signed [UB+1:0]  nx_reg, ny_reg, nz_reg;
    logic                  live4_reg;

    logic                  sq_vld;
    logic [L_W-1:0]        len;
    logic [TAG_W-1:0]      sq_tag;
    logic signed [C_W-1:0] tx, ty;
    logic [C_W-1:0]        mx, my;
    logic                  dv_vld;
    logic [1:0]            dx_tag;
    logic                  dy_tag, dz_tag;
    logic [Q_W-1:0]        qx, qy, qz;
    logic signed [UB+1:0]  vx, vy, vz;

    assign sqx_next = x0_reg * x0_reg;
    assign sqy_next = y0_reg * y0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= vld_in;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= sq_vld;
            vld4_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg    <= x_in;
            y0_reg    <= y_in;
            live0_reg <= live_in;
            sqx_reg   <= S_W'(sqx_next);
            sqy_reg   <= S_W'(sqy_next);
            x1_reg    <= x0_reg;
            y1_reg    <= y0_reg;
            live1_reg <= live0_reg;
            s_reg     <= sqx_reg + sqy_reg + S_W'(16);
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            live2_reg <= live1_reg;
        end
    end

    hvn_isqrt #(
        .RAD_W (RAD_W),
        .TAG_W (TAG_W)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vld2_reg),
        .rad     ({s_reg, {(2*LEN_HALF_SHIFT){1'b0}}}),
        .tag_in  ({live2_reg, x2_reg, y2_reg}),
        .vld_out (sq_vld),
        .root    (len),
        .tag_out (sq_tag)
    );

    assign tx = sq_tag[2*C_W-1:C_W];
    assign ty = sq_tag[C_W-1:0];
    assign mx = tx[C_W-1] ? C_W'(-tx) : C_W'(tx);
    assign my = ty[C_W-1] ? C_W'(-ty) : C_W'(ty);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg  <= (NUM_W'(mx) << SH) + NUM_W'(len);
            numy_reg  <= (NUM_W'(my) << SH) + NUM_W'(len);
            numz_reg  <= (NUM_W'(Z_CROSS) << SH) + NUM_W'(len);
            den_reg   <= {len, 1'b0};
            sx_reg    <= tx[C_W-1];
            sy_reg    <= ty[C_W-1];
            live3_reg <= sq_tag[TAG_W-1];
        end
    end

    hvn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(2)) u_div_x (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (vld3_reg),
        .num (numx_reg), .den (den_reg), .tag_in ({live3_reg, sx_reg}),
        .vld_out (dv_vld), .quo (qx), .tag_out (dx_tag)
    );

    hvn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(1)) u_div_y (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (vld3_reg),
        .num (numy_reg), .den (den_reg), .tag_in (sy_reg),
        .vld_out (), .quo (qy), .tag_out (dy_tag)
    );

    hvn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(1)) u_div_z (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (vld3_reg),
        .num (numz_reg), .den (den_reg), .tag_in (1'b0),
        .vld_out (), .quo (qz), .tag_out (dz_tag)
    );

    assign vx = dx_tag[0] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign vy = dy_tag    ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    assign vz = dz_tag    ? -$signed({1'b0, qz}) : $signed({1'b0, qz});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg    <= dx_tag[1] ? vx : '0;
            ny_reg    <= dx_tag[1] ? vy : '0;
            nz_reg    <= dx_tag[1] ? vz : '0;
            live4_reg <= dx_tag[1];
        end
    end

    assign vld_out  = vld4_reg;
    assign live_out = live4_reg;
    assign nx       = nx_reg;
    assign ny       = ny_reg;
    assign nz       = nz_reg;

endmodule

// ===== design/hvn_merge.sv =====
// Merge stage: sums the lane unit vectors and normalizes the sum to Q1.F.
// Depends on hvn_pkg, hvn_isqrt and hvn_div.
module hvn_merge #(
    parameter int UB = hvn_pkg::NORMAL_FRAC_BITS_DEF + hvn_pkg::GUARD_BITS,
    parameter int F  = hvn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                vld_in,
    input  logic [hvn_pkg::NUM_LANES-1:0]       live,
    input  logic signed [UB+1:0]                lane_n [hvn_pkg::NUM_LANES][3],
    output logic                                vld_out,
    output logic signed [hvn_pkg::NORM_W-1:0]   nx,
    output logic signed [hvn_pkg::NORM_W-1:0]   ny,
    output logic signed [hvn_pkg::NORM_W-1:0]   nz,
    output logic                                none
);

    import hvn_pkg::*;

    localparam int A_W   = UB + 4;
    localparam int T_W   = 2 * A_W;
    localparam int NUM_W = A_W + F + 1;
    localparam int DEN_W = A_W + 1;
    localparam int Q_W   = F + 1;
    localparam int TAG_W = 3 * A_W + 1;
    localparam logic [Q_W-1:0] LIM = Q_W'(1) << F;

    logic                  vp_reg, va_reg, vq_reg, vt_reg, vd_reg, vo_reg;
    logic                  np_reg, na_reg, nq_reg, nt_reg, nd_reg, no_reg;
    logic signed [A_W-1:0] pair_reg [3][NUM_PAIRS];
    logic signed [A_W-1:0] acc_reg  [3];
    logic signed [A_W-1:0] acc_next [3];
    logic signed [A_W-1:0] accq_reg [3];
    logic signed [A_W-1:0] acct_reg [3];
    logic [T_W-1:0]        sq_reg   [3];
    logic [T_W-1:0]        t_reg;
    logic [NUM_W-1:0]      num_reg  [3];
    logic [DEN_W-1:0]      den_reg;
    logic [2:0]            sgn_reg;
    logic signed [NORM_W-1:0] out_reg [3];

    logic                  rt_vld;
    logic [A_W-1:0]        root;
    logic [A_W-1:0]        m0;
    logic [TAG_W-1:0]      rt_tag;
    logic signed [A_W-1:0] ra [3];
    logic [A_W-2:0]        mag [3];
    logic                  dv_vld;
    logic [Q_W-1:0]        quo [3];
    logic [1:0]            tag_x;
    logic                  tag_y, tag_z;
    logic                  sgn_o [3];
    logic signed [F+1:0]   sval [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = pair_reg[c][0];
            for (int p = 1; p < NUM_PAIRS; p++)
            begin
                acc_next[c] = acc_next[c] + pair_reg[c][p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            va_reg <= 1'b0;
            vq_reg <= 1'b0;
            vt_reg <= 1'b0;
            vd_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg <= vld_in;
            va_reg <= vp_reg;
            vq_reg <= va_reg;
            vt_reg <= vq_reg;
            vd_reg <= rt_vld;
            vo_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int p = 0; p < NUM_PAIRS; p++)
                begin
                    pair_reg[c][p] <= A_W'(lane_n[2*p][c]) + A_W'(lane_n[2*p+1][c]);
                end
                acc_reg[c]  <= acc_next[c];
                sq_reg[c]   <= T_W'(acc_reg[c] * acc_reg[c]);
                accq_reg[c] <= acc_reg[c];
                acct_reg[c] <= accq_reg[c];
            end
            np_reg <= ~|live;
            na_reg <= np_reg;
            nq_reg <= na_reg;
            nt_reg <= nq_reg;
            t_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    hvn_isqrt #(
        .RAD_W (T_W),
        .TAG_W (TAG_W)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vt_reg),
        .rad     (t_reg),
        .tag_in  ({nt_reg, acct_reg[C_X], acct_reg[C_Y], acct_reg[C_Z]}),
        .vld_out (rt_vld),
        .root    (root),
        .tag_out (rt_tag)
    );

    assign ra[C_X] = rt_tag[3*A_W-1:2*A_W];
    assign ra[C_Y] = rt_tag[2*A_W-1:A_W];
    assign ra[C_Z] = rt_tag[A_W-1:0];
    assign m0      = (root == '0) ? A_W'(1) : root;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mag[c] = ra[c][A_W-1] ? (A_W-1)'(-ra[c]) : (A_W-1)'(ra[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c] <= (NUM_W'(mag[c]) << (F + 1)) + NUM_W'(m0);
                sgn_reg[c] <= ra[c][A_W-1];
            end
            den_reg <= {m0, 1'b0};
            nd_reg  <= rt_tag[TAG_W-1];
        end
    end

    hvn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(2)) u_div_x (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (vd_reg),
        .num (num_reg[C_X]), .den (den_reg), .tag_in ({nd_reg, sgn_reg[C_X]}),
        .vld_out (dv_vld), .quo (quo[C_X]), .tag_out (tag_x)
    );

    hvn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(1)) u_div_y (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (vd_reg),
        .num (num_reg[C_Y]), .den (den_reg), .tag_in (sgn_reg[C_Y]),
        .vld_out (), .quo (quo[C_Y]), .tag_out (tag_y)
    );

    hvn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(1)) u_div_z (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (vd_reg),
        .num (num_reg[C_Z]), .den (den_reg), .tag_in (sgn_reg[C_Z]),
        .vld_out (), .quo (quo[C_Z]), .tag_out (tag_z)
    );

    assign sgn_o[C_X] = tag_x[0];
    assign sgn_o[C_Y] = tag_y;
    assign sgn_o[C_Z] = tag_z;

    always_comb
    begin
        logic [Q_W-1:0] qc;
        for (int c = 0; c < 3; c++)
        begin
            qc      = (quo[c] > LIM) ? LIM : quo[c];
            sval[c] = sgn_o[c] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_reg[c] <= NORM_W'(sval[c]);
            end
            no_reg <= tag_x[1];
        end
    end

    assign vld_out = vo_reg;
    assign nx      = out_reg[C_X];
    assign ny      = out_reg[C_Y];
    assign nz      = out_reg[C_Z];
    assign none    = no_reg;

endmodule

// ===== design/heightmap_vertex_normal_unit.sv =====
// Vertex normal of a triangulated heightmap: six triangle lanes work in parallel on the fan
// around one vertex, and a merge stage sums and renormalizes their unit vectors. One vertex
// is taken every cycle while the skid buffer is empty; the lanes and the merge stage use
// bit-per-stage square roots and dividers. A one-entry skid buffer holds a result while the
// sink stalls, so input is taken in that cycle too. Outputs are signed Q1.NORMAL_FRAC_BITS;
// with no triangle the normal is zero and tuser is set. Depends on hvn_pkg, hvn_lane and
// hvn_merge.
module heightmap_vertex_normal_unit #(
    parameter int HEIGHT_BITS      = hvn_pkg::HEIGHT_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = hvn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // h_center, h_left, h_down, h_up_left, h_up, h_down_right, h_right,
    // has_left, has_right, has_down, has_up, zero fill
    input  logic [((hvn_pkg::NUM_HEIGHTS*HEIGHT_BITS+hvn_pkg::NUM_FLAGS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // normal_x, normal_y, normal_z
    output logic [3*hvn_pkg::NORM_W-1:0] m_tdata,
    // no_triangle
    output logic [0:0] m_tuser
);

    import hvn_pkg::*;

    localparam int HB = HEIGHT_BITS;
    localparam int UB = NORMAL_FRAC_BITS + GUARD_BITS;
    localparam int FB = NUM_HEIGHTS * HB;

    logic                   en;
    logic [HB-1:0]          h [NUM_HEIGHTS];
    logic                   f_left, f_right, f_down, f_up;
    logic signed [HB:0]     tx [NUM_LANES];
    logic signed [HB:0]     ty [NUM_LANES];
    logic [NUM_LANES-1:0]   tlive;
    logic [NUM_LANES-1:0]   lane_vld;
    logic [NUM_LANES-1:0]   lane_live;
    logic signed [UB+1:0]   lane_n [NUM_LANES][3];

    logic                   p_vld;
    logic signed [NORM_W-1:0] p_x, p_y, p_z;
    logic                   p_none;

    logic                   skid_vld_reg;
    logic [3*NORM_W-1:0]    skid_data_reg;
    logic                   skid_none_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < NUM_HEIGHTS; i++)
        begin
            h[i] = s_tdata[i*HB +: HB];
        end
    end

    assign f_left  = s_tdata[FB + F_LEFT];
    assign f_right = s_tdata[FB + F_RIGHT];
    assign f_down  = s_tdata[FB + F_DOWN];
    assign f_up    = s_tdata[FB + F_UP];

    function automatic logic signed [HB:0] hdiff(input logic [HB-1:0] a, input logic [HB-1:0] b);
        hdiff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    assign tx[0] = hdiff(h[H_LEFT], h[H_CENTER]);
    assign ty[0] = hdiff(h[H_DOWN], h[H_CENTER]);
    assign tx[1] = hdiff(h[H_LEFT], h[H_CENTER]);
    assign ty[1] = hdiff(h[H_LEFT], h[H_UP_LEFT]);
    assign tx[2] = hdiff(h[H_UP_LEFT], h[H_UP]);
    assign ty[2] = hdiff(h[H_CENTER], h[H_UP]);
    assign tx[3] = hdiff(h[H_DOWN], h[H_DOWN_RIGHT]);
    assign ty[3] = hdiff(h[H_DOWN], h[H_CENTER]);
    assign tx[4] = hdiff(h[H_CENTER], h[H_RIGHT]);
    assign ty[4] = hdiff(h[H_DOWN_RIGHT], h[H_RIGHT]);
    assign tx[5] = hdiff(h[H_CENTER], h[H_RIGHT]);
    assign ty[5] = hdiff(h[H_CENTER], h[H_UP]);

    assign tlive[0] = f_left & f_down;
    assign tlive[1] = f_left & f_up;
    assign tlive[2] = f_left & f_up;
    assign tlive[3] = f_right & f_down;
    assign tlive[4] = f_right & f_down;
    assign tlive[5] = f_right & f_up;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        hvn_lane #(
            .HB (HB),
            .UB (UB)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (s_tvalid),
            .live_in  (tlive[i]),
            .x_in     (tx[i]),
            .y_in     (ty[i]),
            .vld_out  (lane_vld[i]),
            .live_out (lane_live[i]),
            .nx       (lane_n[i][C_X]),
            .ny       (lane_n[i][C_Y]),
            .nz       (lane_n[i][C_Z])
        );
    end

    hvn_merge #(
        .UB (UB),
        .F  (NORMAL_FRAC_BITS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (lane_vld[0]),
        .live    (lane_live),
        .lane_n  (lane_n),
        .vld_out (p_vld),
        .nx      (p_x),
        .ny      (p_y),
        .nz      (p_z),
        .none    (p_none)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            skid_vld_reg <= p_vld && !m_tready;
        end
        else if (m_tready)
        begin
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            skid_data_reg <= {p_z, p_y, p_x};
            skid_none_reg <= p_none;
        end
    end

    assign m_tvalid   = skid_vld_reg || p_vld;
    assign m_tdata    = skid_vld_reg ? skid_data_reg : {p_z, p_y, p_x};
    assign m_tuser[0] = skid_vld_reg ? skid_none_reg : p_none;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        lane_vld == {NUM_LANES{lane_vld[0]}})
        else $error("lane valid bits disagree");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(p_vld && !m_tready))
        else $error("skid filled without a stalled result");

    a_no_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero normal with no triangle");

    a_skid_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg && !m_tready |=> $stable(m_tdata) && m_tvalid)
        else $error("held result changed under stall");

endmodule
